[hw/rtl/digit_packet_checksum_deframer_top_assert.svh]
// Assertion macros for the digit packet checksum deframer.
// Each macro expects clk and rst in scope.
`ifndef DIGIT_PACKET_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH
`define DIGIT_PACKET_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DPCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dpcd_pkg.sv]
package dpcd_pkg;

  localparam int DIGIT_W = 4;
  localparam int CFG_W = 6;
  localparam int SUM_W = 9;
  localparam int LEN_RESET = 15;
  localparam int DEC_BASE = 10;
  localparam int RECIP_MUL = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W = SUM_W + 8;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SUM_W-1:0] sum_t;

  function automatic digit_t sum_mod10(input sum_t s);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    sum_t rem;
    prod = PROD_W'(s) * PROD_W'(RECIP_MUL);
    quot = prod[PROD_W-1:RECIP_SHIFT];
    rem = s - SUM_W'(quot) * SUM_W'(DEC_BASE);
    return rem[DIGIT_W-1:0];
  endfunction

  function automatic digit_t xor_mod10(input digit_t x);
    return (x >= DIGIT_W'(DEC_BASE)) ? x - DIGIT_W'(DEC_BASE) : x;
  endfunction

endpackage

[hw/rtl/digit_packet_checksum_deframer_top.sv]
// Throughput when not stalled: one digit per cycle in, one payload digit per cycle out.
// Output path: after the transfer of the second check digit, the first payload
// digit passes the window ring memory read, then the output register.
// Input stalls on a taken config write, and while a packet drains if the next
// digit would close a window or its ring slot is still unread by the drain read port.
// Reset: window empty, packet length 15; the ring memory is not cleared.
module digit_packet_checksum_deframer_top #(
  parameter int MAX_PACKET = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpcd_pkg::DIGIT_W-1:0]  digit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpcd_pkg::DIGIT_W-1:0]  payload_digit,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpcd_pkg::CFG_W-1:0]    packet_length
);

  localparam int DEPTH = MAX_PACKET + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(MAX_PACKET + 3);
  localparam int LW = $clog2(MAX_PACKET + 1);

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  dpcd_pkg::digit_t win_mem [DEPTH];

  logic [dpcd_pkg::CFG_W-1:0] plen, plen_next;
  logic [FW-1:0] fill, fill_next;
  dpcd_pkg::sum_t run_sum, run_sum_next;
  dpcd_pkg::digit_t run_xor, run_xor_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [LW-1:0] cnt, cnt_next;
  logic old_sel, old_sel_next;
  logic s1_v, s1_v_next;
  logic s1_last, s1_last_next;
  logic o_v, o_v_next;
  dpcd_pkg::digit_t last1, last1_next;
  dpcd_pkg::digit_t last2, last2_next;
  dpcd_pkg::digit_t old_reg, old_reg_next;
  dpcd_pkg::digit_t old_q;
  dpcd_pkg::digit_t pay_q;

  logic [LW-1:0] len_eff;
  logic [FW-1:0] need, need_m1, fill_inc;
  logic cfg_fire, in_fire, cnt_busy, grow, check, match, slide;
  logic old_rd_en, o_fire, o_free, s1_move, issue;
  logic [AW-1:0] old_addr;
  dpcd_pkg::sum_t sum_acc;
  dpcd_pkg::digit_t xor_acc, oldest;

  always_comb begin
    len_eff = ({1'b0, plen} > (dpcd_pkg::CFG_W + 1)'(MAX_PACKET)) ?
              LW'(MAX_PACKET) : plen[LW-1:0];
    need = FW'(len_eff) + FW'(2);
    need_m1 = FW'(len_eff) + FW'(1);
    cnt_busy = (cnt != '0);
    cfg_ready = !cnt_busy && !s1_v && !o_v;
    cfg_fire = cfg_valid && cfg_ready;
    in_stall = cfg_fire || (cnt_busy && ((fill == need_m1) || (wptr == rptr)));
    in_fire = in_valid && !in_stall;
    fill_inc = fill + 1'b1;
    grow = (fill_inc >= FW'(3));
    sum_acc = grow ? run_sum + dpcd_pkg::SUM_W'(last2) : run_sum;
    xor_acc = grow ? (run_xor ^ last2) : run_xor;
    check = (fill_inc == need);
    match = check && (last1 == dpcd_pkg::sum_mod10(sum_acc)) &&
            (digit == dpcd_pkg::xor_mod10(xor_acc));
    slide = check && !match;
    oldest = old_sel ? old_q : old_reg;
    old_addr = ring_inc(head);

    o_fire = o_v && !out_stall;
    o_free = !o_v || o_fire;
    s1_move = s1_v && o_free;
    issue = cnt_busy && (!s1_v || s1_move);

    plen_next = plen;
    fill_next = fill;
    run_sum_next = run_sum;
    run_xor_next = run_xor;
    head_next = head;
    wptr_next = wptr;
    rptr_next = rptr;
    cnt_next = cnt;
    old_sel_next = old_sel;
    old_reg_next = old_reg;
    last1_next = last1;
    last2_next = last2;
    old_rd_en = 1'b0;

    if (issue) begin
      cnt_next = cnt - 1'b1;
      rptr_next = ring_inc(rptr);
    end

    if (cfg_fire) begin
      plen_next = packet_length;
      fill_next = '0;
      run_sum_next = '0;
      run_xor_next = '0;
      head_next = wptr;
    end else if (in_fire) begin
      wptr_next = ring_inc(wptr);
      last1_next = digit;
      last2_next = last1;
      if (match) begin
        fill_next = '0;
        run_sum_next = '0;
        run_xor_next = '0;
        head_next = ring_inc(wptr);
        cnt_next = len_eff;
        rptr_next = head;
      end else if (slide) begin
        old_rd_en = 1'b1;
        old_sel_next = 1'b1;
        head_next = old_addr;
        if (len_eff == '0) begin
          run_sum_next = '0;
          run_xor_next = '0;
        end else begin
          run_sum_next = sum_acc - dpcd_pkg::SUM_W'(oldest);
          run_xor_next = xor_acc ^ oldest;
        end
      end else begin
        fill_next = fill_inc;
        run_sum_next = sum_acc;
        run_xor_next = xor_acc;
        if (fill == '0) begin
          old_reg_next = digit;
          old_sel_next = 1'b0;
        end
      end
    end

    s1_v_next = issue ? 1'b1 : (s1_move ? 1'b0 : s1_v);
    s1_last_next = issue ? (cnt == LW'(1)) : s1_last;
    o_v_next = s1_move ? 1'b1 : (o_fire ? 1'b0 : o_v);

    out_valid = o_v;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_mem[wptr] <= digit;
    end
    if (old_rd_en) begin
      old_q <= (old_addr == wptr) ? digit : win_mem[old_addr];
    end
    if (issue) begin
      pay_q <= win_mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= dpcd_pkg::CFG_W'(dpcd_pkg::LEN_RESET);
      fill <= '0;
      run_sum <= '0;
      run_xor <= '0;
      head <= '0;
      wptr <= '0;
      cnt <= '0;
      old_sel <= 1'b0;
      s1_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      plen <= plen_next;
      fill <= fill_next;
      run_sum <= run_sum_next;
      run_xor <= run_xor_next;
      head <= head_next;
      wptr <= wptr_next;
      cnt <= cnt_next;
      old_sel <= old_sel_next;
      s1_v <= s1_v_next;
      o_v <= o_v_next;
    end
  end

  always_ff @(posedge clk) begin
    rptr <= rptr_next;
    s1_last <= s1_last_next;
    last1 <= last1_next;
    last2 <= last2_next;
    old_reg <= old_reg_next;
    if (s1_move) begin
      payload_digit <= pay_q;
      last <= s1_last;
    end
  end

endmodule

[hw/rtl/dpcd_checker.sv]
`include "digit_packet_checksum_deframer_top_assert.svh"

module dpcd_assert_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [dpcd_pkg::DIGIT_W-1:0]  digit,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dpcd_pkg::DIGIT_W-1:0]  payload_digit,
  input logic                          last,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [dpcd_pkg::CFG_W-1:0]    packet_length
);

  `DPCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(payload_digit) && $stable(last),
    "stalled result changed")

  `DPCD_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last,
    out_valid, "gap inside a packet transfer")

  `DPCD_ASSERT_NOW(a_busy_no_cfg, out_valid, !cfg_ready,
    "config ready while a packet drains")

  `DPCD_ASSERT_NEXT(a_cfg_quiet, cfg_valid && cfg_ready, !out_valid,
    "result shown right after a config write")

endmodule

bind digit_packet_checksum_deframer_top dpcd_assert_checker u_dpcd_assert_checker (.*);
